// ===== sv/hsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared constants, types and helpers of the Huffman stream decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int NODE_COUNT   = 511;
    localparam int HOLD_DEPTH   = 8;

    // Node word: leaf flag, symbol, left child, right child.
    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;
    localparam int WORD_W = 1 + SYM_W + 2 * IDX_W;
    localparam int LEAF_B = WORD_W - 1;

    // Bit stream phases.
    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_RAW   = 3'd1;
    localparam logic [2:0] PH_PAD   = 3'd2;
    localparam logic [2:0] PH_COUNT = 3'd3;
    localparam logic [2:0] PH_TFLAG = 3'd4;
    localparam logic [2:0] PH_TSYM  = 3'd5;
    localparam logic [2:0] PH_DATA  = 3'd6;

    // Request from the bit engine to the hold queue and output stage.
    typedef struct packed {
        logic             push;
        logic             flush;
        logic             clear;
        logic [SYM_W-1:0] sym;
        logic [2:0]       drop;
    } t_emit_req;

    // Pad symbols to drop: pad count, or pad count over the leftmost depth.
    function automatic logic [2:0] drop_calc(logic [2:0] pad, logic [3:0] depth);
        logic [3:0] rem;
        logic [2:0] quo;
        begin
            rem = {1'b0, pad};
            quo = 3'd0;
            if (depth < 4'd2) begin
                return pad;
            end
            for (int k = 0; k < 3; k++) begin
                if (rem >= depth) begin
                    rem = rem - depth;
                    quo = quo + 3'd1;
                end
            end
            return quo;
        end
    endfunction

endpackage

// ===== sv/huffman_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Decodes a byte stream that carries its own postorder Huffman tree.
// ----------------------------------------------------------------------------
// One compressed byte is taken at a time and worked off bit by bit before the
// next one is accepted. A raw-mode byte is passed straight on. Header and tree
// bits are read in the bit state, a merge does one build-stack read, and the
// tree finish does a merge per collapsing step plus up to nine node-store reads
// for the leftmost depth. Each code bit does one node-store read for the child;
// a single-leaf tree takes one cycle per bit while the output can take its
// symbols. A full output register stalls the bit engine when a decoded byte
// must leave.
module huffman_stream_decoder #(
    parameter int SYMBOL_COUNT = hsd_pkg::SYMBOL_COUNT,
    parameter int NODE_COUNT   = hsd_pkg::NODE_COUNT,
    parameter int HOLD_DEPTH   = hsd_pkg::HOLD_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    localparam int IW  = hsd_pkg::IDX_W;
    localparam int WW  = hsd_pkg::WORD_W;
    localparam int LB  = hsd_pkg::LEAF_B;
    localparam int SAW = $clog2(SYMBOL_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RAW   = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DEPTH = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;
    localparam logic [2:0] S_END   = 3'd7;

    logic [2:0]    r_st, n_st;
    logic [7:0]    r_byte, n_byte;
    logic          r_eos, n_eos;
    logic [2:0]    r_bit, n_bit;
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_pad, n_pad;
    logic [7:0]    r_hshift, n_hshift;
    logic [3:0]    r_hbits, n_hbits;
    logic [8:0]    r_lrem, n_lrem;
    logic [IW-1:0] r_nf, n_nf;
    logic [8:0]    r_top, n_top;
    logic [IW-1:0] r_tos, n_tos;
    logic [IW-1:0] r_root, n_root;
    logic [WW-1:0] r_root_word, n_root_word;
    logic [WW-1:0] r_walk_word, n_walk_word;
    logic [3:0]    r_depth, n_depth;
    logic [2:0]    r_drop, n_drop;
    logic          r_fin, n_fin;

    logic          node_we, node_re;
    logic [IW-1:0] node_waddr, node_raddr;
    logic [WW-1:0] node_wdata, node_rdata;
    logic          stk_we, stk_re;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [IW-1:0] stk_wdata, stk_rdata;

    hsd_pkg::t_emit_req req;
    logic               emit_ready;

    logic          b;
    logic [7:0]    sh;
    logic [8:0]    total;
    logic [8:0]    lr;
    logic [8:0]    top_m2;
    logic [IW-1:0] child;
    logic          node_room;

    assign b         = r_byte[r_bit];
    assign sh        = r_hshift | (8'(b) << r_hbits[2:0]);
    assign top_m2    = r_top - 9'd2;
    assign node_room = r_nf < IW'(NODE_COUNT);
    assign o_in_stall = (r_st != S_IDLE);

    always_comb begin
        n_st        = r_st;
        n_byte      = r_byte;
        n_eos       = r_eos;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_pad       = r_pad;
        n_hshift    = r_hshift;
        n_hbits     = r_hbits;
        n_lrem      = r_lrem;
        n_nf        = r_nf;
        n_top       = r_top;
        n_tos       = r_tos;
        n_root      = r_root;
        n_root_word = r_root_word;
        n_walk_word = r_walk_word;
        n_depth     = r_depth;
        n_drop      = r_drop;
        n_fin       = r_fin;
        node_we     = 1'b0;
        node_waddr  = r_nf;
        node_wdata  = '0;
        node_re     = 1'b0;
        node_raddr  = r_root;
        stk_we      = 1'b0;
        stk_waddr   = r_top[SAW-1:0];
        stk_wdata   = r_nf;
        stk_re      = 1'b0;
        stk_raddr   = top_m2[SAW-1:0];
        req.push    = 1'b0;
        req.flush   = 1'b0;
        req.clear   = 1'b0;
        req.sym     = r_byte;
        req.drop    = r_drop;
        total       = 9'd0;
        lr          = 9'd0;
        child       = '0;

        unique case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_in_byte;
                    n_eos  = i_end_of_stream;
                    n_bit  = 3'd0;
                    n_st   = (r_phase == hsd_pkg::PH_RAW) ? S_RAW : S_BIT;
                end
            end
            S_RAW: begin
                req.push = 1'b1;
                if (emit_ready) begin
                    n_st = S_END;
                end
            end
            S_BIT: begin
                // By default the engine moves on to the next bit of the byte.
                n_bit = r_bit + 3'd1;
                n_st  = (r_bit == 3'd7) ? S_END : S_BIT;
                unique case (r_phase)
                    hsd_pkg::PH_FLAG: begin
                        if (!b) begin
                            n_phase = hsd_pkg::PH_RAW;
                            n_st    = S_END;
                        end else begin
                            n_phase  = hsd_pkg::PH_PAD;
                            n_hshift = 8'd0;
                            n_hbits  = 4'd0;
                        end
                    end
                    hsd_pkg::PH_PAD: begin
                        n_pad   = r_pad | (3'(b) << r_hbits[1:0]);
                        n_hbits = r_hbits + 4'd1;
                        if (r_hbits == 4'd2) begin
                            n_phase  = hsd_pkg::PH_COUNT;
                            n_hbits  = 4'd0;
                            n_hshift = 8'd0;
                        end
                    end
                    hsd_pkg::PH_COUNT, hsd_pkg::PH_TSYM: begin
                        if (r_hbits != 4'd7) begin
                            n_hshift = sh;
                            n_hbits  = r_hbits + 4'd1;
                        end else begin
                            n_hbits  = 4'd0;
                            n_hshift = 8'd0;
                            if (r_phase == hsd_pkg::PH_COUNT) begin
                                total = {1'b0, sh} + 9'd1;
                                if (total > 9'(SYMBOL_COUNT)) begin
                                    total = 9'(SYMBOL_COUNT);
                                end
                                n_lrem  = total;
                                n_phase = hsd_pkg::PH_TFLAG;
                            end else begin
                                if (r_top < 9'(SYMBOL_COUNT) && node_room) begin
                                    node_we    = 1'b1;
                                    node_wdata = {1'b1, sh, {(2*IW){1'b0}}};
                                    stk_we     = 1'b1;
                                    n_tos      = r_nf;
                                    n_top      = r_top + 9'd1;
                                    n_nf       = r_nf + IW'(1);
                                end
                                lr     = (r_lrem != 9'd0) ? r_lrem - 9'd1 : 9'd0;
                                n_lrem = lr;
                                if (lr == 9'd0) begin
                                    n_bit = r_bit;
                                    n_st  = S_FIN;
                                end else begin
                                    n_phase = hsd_pkg::PH_TFLAG;
                                end
                            end
                        end
                    end
                    hsd_pkg::PH_TFLAG: begin
                        if (b) begin
                            n_phase  = hsd_pkg::PH_TSYM;
                            n_hshift = 8'd0;
                            n_hbits  = 4'd0;
                        end else if (r_top >= 9'd2) begin
                            stk_re = 1'b1;
                            n_fin  = 1'b0;
                            n_bit  = r_bit;
                            n_st   = S_MERGE;
                        end
                    end
                    hsd_pkg::PH_DATA: begin
                        if (r_root_word[LB]) begin
                            // A single-leaf tree gives its symbol for every bit.
                            req.push = 1'b1;
                            req.sym  = r_root_word[LB-1 -: 8];
                            if (!emit_ready) begin
                                n_bit = r_bit;
                                n_st  = S_BIT;
                            end
                        end else begin
                            child = b ? r_walk_word[IW-1:0] : r_walk_word[2*IW-1:IW];
                            if (child >= IW'(NODE_COUNT)) begin
                                child = r_root;
                            end
                            node_re    = 1'b1;
                            node_raddr = child;
                            n_bit      = r_bit;
                            n_st       = S_WALK;
                        end
                    end
                    default: begin
                        n_bit = r_bit;
                        n_st  = S_END;
                    end
                endcase
            end
            S_MERGE: begin
                if (node_room) begin
                    node_we    = 1'b1;
                    node_wdata = {1'b0, 8'd0, stk_rdata, r_tos};
                    stk_we     = 1'b1;
                    stk_waddr  = top_m2[SAW-1:0];
                    n_tos      = r_nf;
                    n_top      = r_top - 9'd1;
                    n_nf       = r_nf + IW'(1);
                end
                if (r_fin) begin
                    n_st = S_FIN;
                end else begin
                    n_bit = r_bit + 3'd1;
                    n_st  = (r_bit == 3'd7) ? S_END : S_BIT;
                end
            end
            S_FIN: begin
                if (r_top > 9'd1 && node_room) begin
                    stk_re = 1'b1;
                    n_fin  = 1'b1;
                    n_st   = S_MERGE;
                end else begin
                    n_root     = (r_top != 9'd0) ? r_tos : '0;
                    node_re    = 1'b1;
                    node_raddr = n_root;
                    n_depth    = 4'd0;
                    n_st       = S_DEPTH;
                end
            end
            S_DEPTH: begin
                if (r_depth == 4'd0) begin
                    n_root_word = node_rdata;
                end
                if (r_depth < 4'd8 && !node_rdata[LB]) begin
                    n_depth    = r_depth + 4'd1;
                    node_re    = 1'b1;
                    node_raddr = node_rdata[2*IW-1:IW];
                end else begin
                    n_drop      = hsd_pkg::drop_calc(r_pad, r_depth);
                    n_walk_word = (r_depth == 4'd0) ? node_rdata : r_root_word;
                    n_phase     = hsd_pkg::PH_DATA;
                    n_bit       = r_bit + 3'd1;
                    n_st        = (r_bit == 3'd7) ? S_END : S_BIT;
                end
            end
            S_WALK: begin
                if (node_rdata[LB]) begin
                    req.push = 1'b1;
                    req.sym  = node_rdata[LB-1 -: 8];
                    if (emit_ready) begin
                        n_walk_word = r_root_word;
                        n_bit       = r_bit + 3'd1;
                        n_st        = (r_bit == 3'd7) ? S_END : S_BIT;
                    end
                end else begin
                    n_walk_word = node_rdata;
                    n_bit       = r_bit + 3'd1;
                    n_st        = (r_bit == 3'd7) ? S_END : S_BIT;
                end
            end
            S_END: begin
                // The last result of the request leaves marked as last.
                req.flush = 1'b1;
                if (emit_ready) begin
                    n_st = S_IDLE;
                    if (r_eos) begin
                        req.clear = 1'b1;
                        n_phase   = hsd_pkg::PH_FLAG;
                        n_pad     = 3'd0;
                        n_hshift  = 8'd0;
                        n_hbits   = 4'd0;
                        n_lrem    = 9'd0;
                        n_nf      = '0;
                        n_top     = 9'd0;
                        n_root    = '0;
                        n_drop    = 3'd0;
                    end
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_phase <= hsd_pkg::PH_FLAG;
            r_pad   <= 3'd0;
            r_hshift <= 8'd0;
            r_hbits <= 4'd0;
            r_lrem  <= 9'd0;
            r_nf    <= '0;
            r_top   <= 9'd0;
            r_root  <= '0;
            r_drop  <= 3'd0;
            r_fin   <= 1'b0;
            r_bit   <= 3'd0;
            r_eos   <= 1'b0;
            r_depth <= 4'd0;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_hshift <= n_hshift;
            r_hbits <= n_hbits;
            r_lrem  <= n_lrem;
            r_nf    <= n_nf;
            r_top   <= n_top;
            r_root  <= n_root;
            r_drop  <= n_drop;
            r_fin   <= n_fin;
            r_bit   <= n_bit;
            r_eos   <= n_eos;
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_tos       <= n_tos;
        r_root_word <= n_root_word;
        r_walk_word <= n_walk_word;
    end

    hsd_ram #(
        .W     (WW),
        .DEPTH (NODE_COUNT),
        .AW    (IW)
    ) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    hsd_ram #(
        .W     (IW),
        .DEPTH (SYMBOL_COUNT),
        .AW    (SAW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    hsd_emit #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_ready       (emit_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= 9'(SYMBOL_COUNT))
        else $error("build stack overflow");

    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= IW'(NODE_COUNT))
        else $error("node store overflow");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_END && r_eos && emit_ready) |=> (r_phase == hsd_pkg::PH_FLAG && r_nf == '0))
        else $error("decoder did not re-arm after end of stream");

    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WALK || r_st == S_DEPTH) |-> !node_we)
        else $error("node store written while walking the tree");

endmodule

// ===== sv/hsd_ram.sv =====
// ----------------------------------------------------------------------------
// hsd_ram
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module hsd_ram #(
    parameter int W     = 27,
    parameter int DEPTH = 511,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/hsd_emit.sv =====
// ----------------------------------------------------------------------------
// hsd_emit
// Hold queue for decoded symbols, one pending result and the output register.
// ----------------------------------------------------------------------------
module hsd_emit #(
    parameter int HOLD_DEPTH = hsd_pkg::HOLD_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hsd_pkg::t_emit_req       i_req,
    output logic                     o_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [hsd_pkg::SYM_W-1:0] o_out_byte,
    output logic                     o_last_of_run
);

    localparam int HAW = $clog2(HOLD_DEPTH);
    localparam int FW  = $clog2(HOLD_DEPTH + 1);

    logic [hsd_pkg::SYM_W-1:0] r_q [HOLD_DEPTH];
    logic [hsd_pkg::SYM_W-1:0] t_q [HOLD_DEPTH];
    logic [FW-1:0]             r_fill;
    logic                      r_pv;
    logic [hsd_pkg::SYM_W-1:0] r_pb;
    logic                      r_ov;
    logic [hsd_pkg::SYM_W-1:0] r_ob;
    logic                      r_ol;
    logic                      out_free;
    logic                      qout;
    logic                      do_push;
    logic                      do_flush;

    assign out_free = !r_ov || !i_out_stall;
    assign o_ready  = !r_pv || out_free;
    assign do_push  = i_req.push && o_ready;
    assign do_flush = i_req.flush && o_ready && r_pv;
    assign qout     = (r_fill + FW'(1)) > FW'(i_req.drop);

    always_comb begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            t_q[i] = r_q[i];
        end
        t_q[r_fill[HAW-1:0]] = i_req.sym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pv   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (out_free) begin
                r_ov <= 1'b0;
            end
            if (do_push) begin
                if (qout) begin
                    r_pv <= 1'b1;
                    if (r_pv) begin
                        r_ov <= 1'b1;
                    end
                end else begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (do_flush) begin
                r_ov <= 1'b1;
                r_pv <= 1'b0;
            end
            if (i_req.clear) begin
                r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            if (qout) begin
                for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                    r_q[i] <= t_q[i+1];
                end
                r_pb <= t_q[0];
                if (r_pv) begin
                    r_ob <= r_pb;
                    r_ol <= 1'b0;
                end
            end else begin
                for (int i = 0; i < HOLD_DEPTH; i++) begin
                    r_q[i] <= t_q[i];
                end
            end
        end
        if (do_flush) begin
            r_ob <= r_pb;
            r_ol <= 1'b1;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_last_of_run = r_ol;

endmodule

// ===== verif/huffman_stream_decoder_test.sv =====
// ----------------------------------------------------------------------------
// huffman_stream_decoder_test
// Self-checking bench: drives raw, coded, truncated and noise streams into
// the decoder and compares every decoded byte with a built-in predictor.
// ----------------------------------------------------------------------------
class huff_scoreboard;

    typedef struct {
        bit [7:0] data;
        bit       last;
    } t_decoded;

    t_decoded   decoded_q[$];
    int         fail_count;

    bit [2:0]   phase;
    bit         raw_done;
    bit [2:0]   pad;
    bit [7:0]   hshift;
    int         hbits;
    int         leaves_rem;
    int         leaf_tot;
    bit [26:0]  nodes[hsd_pkg::NODE_COUNT];
    int         nfree;
    bit [8:0]   stk[hsd_pkg::SYMBOL_COUNT];
    int         top;
    int         root;
    int         walk;
    int         drop;
    bit [7:0]   hold[hsd_pkg::HOLD_DEPTH];
    int         fill;

    function new();
        fail_count = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase      = hsd_pkg::PH_FLAG;
        raw_done   = 0;
        pad        = 0;
        hshift     = 0;
        hbits      = 0;
        leaves_rem = 0;
        leaf_tot   = 0;
        nfree      = 0;
        top        = 0;
        root       = 0;
        walk       = 0;
        drop       = 0;
        fill       = 0;
        foreach (nodes[k]) nodes[k] = '0;
    endfunction

    function bit is_leaf(int idx);
        return idx < hsd_pkg::NODE_COUNT && nodes[idx][26];
    endfunction

    function void merge_top();
        bit [8:0] l;
        bit [8:0] r;
        if (top < 2 || nfree >= hsd_pkg::NODE_COUNT) return;
        r = stk[top-1];
        l = stk[top-2];
        nodes[nfree] = {1'b0, 8'd0, l, r};
        stk[top-2] = nfree[8:0];
        nfree++;
        top--;
    endfunction

    function void finish_tree();
        int depth;
        int n;
        int prev;
        depth = 0;
        while (top > 1) begin
            prev = top;
            merge_top();
            if (top == prev) break;
        end
        root = top ? int'(stk[top-1]) : 0;
        n = root;
        while (depth < 8 && n < hsd_pkg::NODE_COUNT && !is_leaf(n)) begin
            depth++;
            n = int'(nodes[n][17:9]);
        end
        drop  = depth < 2 ? int'(pad) : int'(pad) / depth;
        walk  = root;
        phase = hsd_pkg::PH_DATA;
    endfunction

    function int push_symbol(bit [7:0] sym, int cnt);
        t_decoded d;
        hold[fill] = sym;
        fill++;
        if (fill > drop) begin
            d.data = hold[0];
            d.last = 0;
            decoded_q = {decoded_q, d};
            for (int k = 0; k < hsd_pkg::HOLD_DEPTH - 1; k++) hold[k] = hold[k+1];
            fill--;
            cnt++;
        end
        return cnt;
    endfunction

    // Works off one accepted request and queues the bytes it decodes to.
    function void note_request(bit [7:0] data, bit eos);
        int       cnt;
        bit       b;
        int       child;
        t_decoded d;
        cnt = 0;
        if (phase == hsd_pkg::PH_RAW && raw_done) begin
            d.data = data;
            d.last = 1;
            decoded_q = {decoded_q, d};
        end else begin
            for (int i = 0; i < 8; i++) begin
                b = data[i];
                if (phase == hsd_pkg::PH_FLAG) begin
                    if (!b) begin
                        phase    = hsd_pkg::PH_RAW;
                        raw_done = 1;
                        break;
                    end
                    phase  = hsd_pkg::PH_PAD;
                    hshift = 0;
                    hbits  = 0;
                end else if (phase == hsd_pkg::PH_PAD) begin
                    pad[hbits] = b;
                    hbits++;
                    if (hbits == 3) begin
                        phase  = hsd_pkg::PH_COUNT;
                        hbits  = 0;
                        hshift = 0;
                    end
                end else if (phase == hsd_pkg::PH_COUNT || phase == hsd_pkg::PH_TSYM) begin
                    hshift[hbits] = b;
                    hbits++;
                    if (hbits < 8) continue;
                    hbits = 0;
                    if (phase == hsd_pkg::PH_COUNT) begin
                        leaf_tot   = int'(hshift) + 1;
                        leaves_rem = leaf_tot;
                        phase      = hsd_pkg::PH_TFLAG;
                    end else begin
                        if (top < hsd_pkg::SYMBOL_COUNT && nfree < hsd_pkg::NODE_COUNT) begin
                            nodes[nfree] = {1'b1, hshift, 18'd0};
                            stk[top] = nfree[8:0];
                            top++;
                            nfree++;
                        end
                        if (leaves_rem > 0) leaves_rem--;
                        if (leaves_rem == 0) finish_tree();
                        else phase = hsd_pkg::PH_TFLAG;
                    end
                    hshift = 0;
                end else if (phase == hsd_pkg::PH_TFLAG) begin
                    if (b) begin
                        phase  = hsd_pkg::PH_TSYM;
                        hshift = 0;
                        hbits  = 0;
                    end else begin
                        merge_top();
                    end
                end else if (phase == hsd_pkg::PH_DATA) begin
                    if (is_leaf(root)) begin
                        cnt = push_symbol(nodes[root][25:18], cnt);
                    end else begin
                        child = b ? int'(nodes[walk][8:0]) : int'(nodes[walk][17:9]);
                        if (child >= hsd_pkg::NODE_COUNT) child = root;
                        if (is_leaf(child)) begin
                            cnt  = push_symbol(nodes[child][25:18], cnt);
                            walk = root;
                        end else begin
                            walk = child;
                        end
                    end
                end else begin
                    break;
                end
            end
            if (cnt > 0) decoded_q[decoded_q.size()-1].last = 1;
        end
        if (eos) clear_state();
    endfunction

    function void check_result(bit [7:0] data, bit last);
        t_decoded d;
        if (decoded_q.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                     $time, data, last);
            fail_count++;
            return;
        end
        d = decoded_q[0];
        decoded_q.delete(0);
        if (d.data !== data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, d.data, data);
            fail_count++;
        end
        if (d.last !== last) begin
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, d.last, last);
            fail_count++;
        end
    endfunction

    function int pending();
        return decoded_q.size();
    endfunction

endclass

module huffman_stream_decoder_test;

    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_stream;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    huff_scoreboard sb;
    bit             stream_bits[$];
    bit             quiet;
    int             hold_off_len;
    int             burst_pct;
    int             cycle_count;
    int             sent_count;

    huffman_stream_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        sb              = new();
        i_rst_n         = 0;
        i_in_valid      = 0;
        i_in_byte       = 0;
        i_end_of_stream = 0;
        i_out_stall     = 0;
        quiet           = 0;
        hold_off_len    = 0;
        burst_pct       = 25;
        cycle_count     = 0;
        sent_count      = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: check accepted bytes, then pick the next stall value.
    initial begin : receiver
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_out_byte, o_last_of_run);
            if (hold_off_len > 0) begin
                hold_off_len = hold_off_len - 1;
                i_out_stall <= 1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1;
            end else if (!quiet && $urandom_range(99) < burst_pct) begin
                burst = $urandom_range(5, 1) - 1;
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    task automatic send_byte(bit [7:0] data, bit eos);
        i_in_valid      <= 1;
        i_in_byte       <= data;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(data, eos);
        sent_count++;
        if (!quiet && $urandom_range(99) < burst_pct) begin
            i_in_valid <= 0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    task automatic put_bits(bit [31:0] value, int n);
        for (int k = 0; k < n; k++) stream_bits = {stream_bits, value[k]};
    endtask

    // Sends the collected bits as bytes; keep_bytes < 0 sends them all.
    task automatic send_bits(int keep_bytes);
        int       nbytes;
        bit [7:0] data;
        nbytes = (stream_bits.size() + 7) / 8;
        if (keep_bytes >= 0 && keep_bytes < nbytes) nbytes = keep_bytes;
        for (int k = 0; k < nbytes; k++) begin
            for (int j = 0; j < 8; j++)
                data[j] = (k*8 + j < stream_bits.size()) ? stream_bits[k*8 + j]
                                                          : 1'($urandom_range(1));
            send_byte(data, k == nbytes - 1);
        end
        stream_bits.delete();
    endtask

    // Coded stream: header, postorder tree, random code bits, with optional stray merge flags and truncation.
    task automatic coded_stream(int leaves, int code_bits, bit [2:0] pad, int keep_bytes,
                                int bogus_merges);
        int left;
        int depth;
        left  = leaves;
        depth = 0;
        put_bits(1, 1);
        put_bits(pad, 3);
        put_bits(leaves - 1, 8);
        repeat (bogus_merges) put_bits(0, 1);
        while (left > 0) begin
            if (depth < 2 || $urandom_range(1)) begin
                put_bits(1, 1);
                put_bits($urandom_range(255), 8);
                depth++;
                left--;
            end else begin
                put_bits(0, 1);
                depth--;
            end
        end
        put_bits(0, 0);
        for (int k = 0; k < code_bits; k++) put_bits($urandom_range(1), 1);
        send_bits(keep_bytes);
    endtask

    task automatic raw_stream(int count);
        send_byte({7'($urandom_range(127)), 1'b0}, count == 0);
        for (int k = 0; k < count; k++) send_byte(8'($urandom_range(255)), k == count - 1);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int kind;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: raw extremes, single leaf, padding, short streams.
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        send_byte(8'hFE, 0);
        send_byte(8'h5A, 1);
        coded_stream(1, 20, 3'd7, -1, 0);
        coded_stream(2, 16, 3'd0, -1, 0);
        coded_stream(5, 24, 3'd7, -1, 2);
        coded_stream(3, 30, 3'd1, -1, 1);
        coded_stream(4, 10, 3'd4, 1, 0);
        coded_stream(6, 10, 3'd2, 3, 0);
        coded_stream(256, 16, 3'd5, 4, 0);
        send_byte(8'hFF, 1);
        drain();

        // The receiver holds off while raw bytes keep coming, so the block fills.
        hold_off_len = 400;
        raw_stream(6);
        drain();

        // Random part; mostly well-formed streams.
        while (sent_count < 262 && cycle_count < 300000) begin
            kind = $urandom_range(99);
            if (kind < 55)
                coded_stream($urandom_range(8, 1), $urandom_range(48, 4),
                             3'($urandom_range(7)), -1, $urandom_range(9) == 0);
            else if (kind < 62)
                coded_stream($urandom_range(60, 9), $urandom_range(40, 8),
                             3'($urandom_range(7)), -1, 0);
            else if (kind < 72)
                coded_stream($urandom_range(8, 1), 24, 3'($urandom_range(7)),
                             $urandom_range(3, 1), 0);
            else if (kind < 90)
                raw_stream($urandom_range(6));
            else
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            if ($urandom_range(30) == 0) drain();
            if ($urandom_range(20) == 0) burst_pct = $urandom_range(1) ? 0 : 35;
        end

        // Closing stretch without idling.
        quiet = 1;
        coded_stream(4, 40, 3'd3, -1, 0);
        raw_stream(4);
        drain();
        @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
